>>> rtl/midpoint_ellipse_rasterizer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the midpoint ellipse rasterizer
// Concurrent property checks that disappear when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define EMR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("emr: implication check failed");
// Next-cycle implication.
`define EMR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("emr: next-cycle check failed");
`else
`define EMR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EMR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/emr_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Widths, register indexes, region codes and the result record.
// ----------------------------------------------------------------------------
package emr_pkg;

	localparam int COORD_WIDTH_DEF = 11;

	localparam int CTR_W   = 10;  // centre coordinates, signed
	localparam int RAD_W   = 9;   // semi-axes, unsigned
	localparam int OFF_W   = 10;  // x offset, unsigned
	localparam int YOFF_W  = 11;  // y offset, signed
	localparam int SQ_W    = 18;  // squared semi-axes
	localparam int SLOPE_W = 30;  // slope terms, signed
	localparam int DEC_W   = 48;  // decision variable, signed
	localparam int MUL_W   = 22;  // multiplier operand width
	localparam int PROD_W  = 2 * MUL_W;
	localparam int SUM_W   = 12;  // exact width of centre plus or minus offset
	localparam int IDX_W   = 2;
	localparam int CFG_W   = 10;

	localparam logic [IDX_W-1:0] CFG_CENTER_X = 2'd0;
	localparam logic [IDX_W-1:0] CFG_CENTER_Y = 2'd1;
	localparam logic [IDX_W-1:0] CFG_RADIUS_X = 2'd2;
	localparam logic [IDX_W-1:0] CFG_RADIUS_Y = 2'd3;

	localparam logic signed [CTR_W-1:0] CENTER_X_RST = 10'sd7;
	localparam logic signed [CTR_W-1:0] CENTER_Y_RST = 10'sd5;
	localparam logic [RAD_W-1:0]        RADIUS_X_RST = 9'd5;
	localparam logic [RAD_W-1:0]        RADIUS_Y_RST = 9'd7;

	typedef enum logic [1:0] {
		RGN_IDLE = 2'd0,
		RGN_ONE  = 2'd1,
		RGN_TWO  = 2'd2,
		RGN_DONE = 2'd3
	} region_t;

	typedef struct packed {
		logic                     valid_res;
		logic                     last;
		logic [OFF_W-1:0]         x_off;
		logic signed [YOFF_W-1:0] y_off;
	} res_t;

endpackage

>>> rtl/emr_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module emr_mul (
	input  logic                       clk,
	input  logic [emr_pkg::MUL_W-1:0]  a,
	input  logic [emr_pkg::MUL_W-1:0]  b,
	output logic [emr_pkg::PROD_W-1:0] prod
);

	logic [emr_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= emr_pkg::PROD_W'(a) * emr_pkg::PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

>>> rtl/emr_walk.sv
// ----------------------------------------------------------------------------
// Ellipse walk sequencer
// Holds the walk state and steps it, using the shared multiplier for setup and for the
// crossing into region two.
`include "midpoint_ellipse_rasterizer_macros.svh"

module emr_walk (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  logic                      cmd_start,
	output logic                      cmd_ready,
	input  logic [emr_pkg::RAD_W-1:0] radius_x,
	input  logic [emr_pkg::RAD_W-1:0] radius_y,
	output logic                      res_valid,
	input  logic                      res_ready,
	output emr_pkg::res_t             res
);

	typedef enum logic [12:0] {
		ST_IDLE = 13'h0001,
		ST_SQX  = 13'h0002,  // rx * rx
		ST_SQY  = 13'h0004,  // ry * ry
		ST_SLP  = 13'h0008,  // sq_rx * ry
		ST_INIT = 13'h0010,  // set up region one
		ST_STEP = 13'h0020,
		ST_HX   = 13'h0040,  // (2x+1)^2
		ST_YM   = 13'h0080,  // (y-1)^2
		ST_T1   = 13'h0100,  // sq_ry * (2x+1)^2
		ST_T2   = 13'h0200,  // sq_rx * (y-1)^2
		ST_T3   = 13'h0400,  // sq_rx * sq_ry
		ST_T4   = 13'h0800,  // finish region two decision
		ST_FIN  = 13'h1000
	} state_t;

	state_t           state_q;
	emr_pkg::region_t region_q;

	logic [emr_pkg::OFF_W-1:0]          x_q;
	logic signed [emr_pkg::YOFF_W-1:0]  y_q;
	logic signed [emr_pkg::SLOPE_W-1:0] slope_x_q, slope_y_q;
	logic signed [emr_pkg::DEC_W-1:0]   dec_q;
	logic [emr_pkg::SQ_W-1:0]           sq_rx_q, sq_ry_q;
	logic [emr_pkg::MUL_W-1:0]          hx2_q, ym2_q;
	emr_pkg::res_t                      res_q;

	logic [emr_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic [emr_pkg::PROD_W-1:0] prod;

	logic signed [emr_pkg::DEC_W-1:0] sx, sy, rxx, ryy, sx1, sy1, p48;
	logic signed [emr_pkg::DEC_W-1:0] d1_lt, d1_ge, d2_ge, d2_lt, d_init;
	logic [emr_pkg::OFF_W:0]          hx;
	logic [emr_pkg::OFF_W-1:0]        aym;
	logic                             go_one;

	emr_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Terms for the region one and region two steps, and for setup.
	always_comb begin
		sx     = emr_pkg::DEC_W'(slope_x_q);
		sy     = emr_pkg::DEC_W'(slope_y_q);
		rxx    = emr_pkg::DEC_W'(sq_rx_q);
		ryy    = emr_pkg::DEC_W'(sq_ry_q);
		p48    = emr_pkg::DEC_W'(prod);
		sx1    = sx + (ryy <<< 1);
		sy1    = sy - (rxx <<< 1);
		d1_lt  = dec_q + ((sx1 + ryy) <<< 2);
		d1_ge  = dec_q + ((sx1 - sy1 + ryy) <<< 2);
		d2_ge  = dec_q + ((rxx - sy1) <<< 2);
		d2_lt  = dec_q + ((sx1 - sy1 + rxx) <<< 2);
		d_init = (ryy <<< 2) - (p48 <<< 2) + rxx;
		hx     = {x_q, 1'b1};
		aym    = (y_q == '0) ? emr_pkg::OFF_W'(1) : emr_pkg::OFF_W'(y_q - 1'b1);
		go_one = (slope_x_q < slope_y_q);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQX: begin
				mul_a = emr_pkg::MUL_W'(radius_x);
				mul_b = emr_pkg::MUL_W'(radius_x);
			end
			ST_SQY: begin
				mul_a = emr_pkg::MUL_W'(radius_y);
				mul_b = emr_pkg::MUL_W'(radius_y);
			end
			ST_SLP: begin
				mul_a = emr_pkg::MUL_W'(sq_rx_q);
				mul_b = emr_pkg::MUL_W'(radius_y);
			end
			ST_HX: begin
				mul_a = emr_pkg::MUL_W'(hx);
				mul_b = emr_pkg::MUL_W'(hx);
			end
			ST_YM: begin
				mul_a = emr_pkg::MUL_W'(aym);
				mul_b = emr_pkg::MUL_W'(aym);
			end
			ST_T1: begin
				mul_a = emr_pkg::MUL_W'(sq_ry_q);
				mul_b = hx2_q;
			end
			ST_T2: begin
				mul_a = emr_pkg::MUL_W'(sq_rx_q);
				mul_b = ym2_q;
			end
			ST_T3: begin
				mul_a = emr_pkg::MUL_W'(sq_rx_q);
				mul_b = emr_pkg::MUL_W'(sq_ry_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			region_q <= emr_pkg::RGN_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= cmd_start ? ST_SQX : ST_STEP;
					end
				end
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_SLP;
				ST_SLP:  state_q <= ST_INIT;
				ST_INIT: begin
					state_q  <= ST_FIN;
					region_q <= emr_pkg::RGN_ONE;
				end
				ST_STEP: begin
					if (region_q == emr_pkg::RGN_ONE && !go_one) begin
						state_q <= ST_HX;
					end else begin
						state_q <= ST_FIN;
						if (region_q == emr_pkg::RGN_TWO && y_q <= 0) begin
							region_q <= emr_pkg::RGN_DONE;
						end
					end
				end
				ST_HX: state_q <= ST_YM;
				ST_YM: state_q <= ST_T1;
				ST_T1: state_q <= ST_T2;
				ST_T2: state_q <= ST_T3;
				ST_T3: state_q <= ST_T4;
				ST_T4: begin
					state_q  <= ST_STEP;
					region_q <= emr_pkg::RGN_TWO;
				end
				ST_FIN: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Walk datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SQY: sq_rx_q <= emr_pkg::SQ_W'(prod);
			ST_SLP: sq_ry_q <= emr_pkg::SQ_W'(prod);
			ST_INIT: begin
				x_q       <= '0;
				y_q       <= emr_pkg::YOFF_W'(radius_y);
				slope_x_q <= '0;
				slope_y_q <= emr_pkg::SLOPE_W'(p48 <<< 1);
				dec_q     <= d_init;
				res_q     <= '0;
			end
			ST_STEP: begin
				res_q <= '0;
				if (region_q == emr_pkg::RGN_ONE) begin
					if (go_one) begin
						res_q.valid_res <= 1'b1;
						res_q.x_off     <= x_q;
						res_q.y_off     <= y_q;
						x_q             <= x_q + 1'b1;
						slope_x_q       <= emr_pkg::SLOPE_W'(sx1);
						if (dec_q[emr_pkg::DEC_W-1]) begin
							dec_q <= d1_lt;
						end else begin
							y_q       <= y_q - 1'b1;
							slope_y_q <= emr_pkg::SLOPE_W'(sy1);
							dec_q     <= d1_ge;
						end
					end
				end else if (region_q == emr_pkg::RGN_TWO) begin
					res_q.valid_res <= 1'b1;
					res_q.x_off     <= x_q;
					res_q.y_off     <= y_q;
					if (y_q <= 0) begin
						res_q.last <= 1'b1;
					end else begin
						y_q       <= y_q - 1'b1;
						slope_y_q <= emr_pkg::SLOPE_W'(sy1);
						if (!dec_q[emr_pkg::DEC_W-1]) begin
							dec_q <= d2_ge;
						end else begin
							x_q       <= x_q + 1'b1;
							slope_x_q <= emr_pkg::SLOPE_W'(sx1);
							dec_q     <= d2_lt;
						end
					end
				end
			end
			ST_YM: hx2_q <= emr_pkg::MUL_W'(prod);
			ST_T1: ym2_q <= emr_pkg::MUL_W'(prod);
			ST_T2: dec_q <= p48;
			ST_T3: dec_q <= dec_q + (p48 <<< 2);
			ST_T4: dec_q <= dec_q - (p48 <<< 2);
			default: ;
		endcase
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_FIN);
	assign res       = res_q;

	`EMR_ASSERT_NXT(a_cmd_leaves_idle, clk, arst_n, cmd_valid && cmd_ready, state_q != ST_IDLE)
	`EMR_ASSERT_NXT(a_start_gives_blank, clk, arst_n, state_q == ST_INIT, state_q == ST_FIN && !res_q.valid_res)
	`EMR_ASSERT_IMP(a_y_not_negative, clk, arst_n, region_q == emr_pkg::RGN_ONE || region_q == emr_pkg::RGN_TWO, !y_q[emr_pkg::YOFF_W-1])
	`EMR_ASSERT_IMP(a_last_ends_walk, clk, arst_n, res_valid && res_q.last, region_q == emr_pkg::RGN_DONE)

endmodule

>>> rtl/midpoint_ellipse_rasterizer.sv
// A start word runs through SQX, SQY, SLP and INIT and gives a blank result; an ordinary
// tick word runs STEP alone; the tick that crosses into region two also runs HX to T4.
// The walk takes one word at a time and stays busy until its result is handed to the output
// register; the start word and the crossing tick form their products on the shared multiplier.
// Reset: arst_n clears the walk to idle, empties the output register and restores the
// centre (7, 5) and semi-axes (5, 7).
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Walks an axis-aligned ellipse one step per tick word, giving four symmetric points.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
	parameter int COORD_WIDTH = emr_pkg::COORD_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Input stream. s_tdata: [0] start_req, rest zero.
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,
	// Output stream. m_tdata: x_right, x_left, y_top, y_bottom from bit 0 up,
	// each COORD_WIDTH bits, zero padding to whole bytes.
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
	// m_tuser: [0] valid_res.
	output logic                      m_tuser,
	output logic                      m_tlast,
	// Configuration writes.
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [emr_pkg::IDX_W-1:0] cfg_index,
	input  logic [emr_pkg::CFG_W-1:0] cfg_data
);

	localparam int TDATA_W = ((4*COORD_WIDTH+7)/8)*8;

	// Configuration registers. The centre is read live whenever a result is
	// formed; the semi-axes are only used while a start word is being set up.
	logic signed [emr_pkg::CTR_W-1:0] center_x_q, center_y_q;
	logic [emr_pkg::RAD_W-1:0]        radius_x_q, radius_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= emr_pkg::CENTER_X_RST;
			center_y_q <= emr_pkg::CENTER_Y_RST;
			radius_x_q <= emr_pkg::RADIUS_X_RST;
			radius_y_q <= emr_pkg::RADIUS_Y_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				emr_pkg::CFG_CENTER_X: center_x_q <= cfg_data;
				emr_pkg::CFG_CENTER_Y: center_y_q <= cfg_data;
				emr_pkg::CFG_RADIUS_X: radius_x_q <= cfg_data[emr_pkg::RAD_W-1:0];
				emr_pkg::CFG_RADIUS_Y: radius_y_q <= cfg_data[emr_pkg::RAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// The walk sequencer takes a word only when idle; its result is handed to
	// the output register as soon as that register is free.
	logic          walk_ready, res_valid, res_ready;
	emr_pkg::res_t res;

	emr_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_start (s_tdata[0]),
		.cmd_ready (walk_ready),
		.radius_x  (radius_x_q),
		.radius_y  (radius_y_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign s_tready = walk_ready;

	// Point coordinates. The sums are exact in SUM_W bits and then wrapped or
	// sign-extended to the coordinate width.
	logic signed [emr_pkg::SUM_W-1:0] cx, cy, xo, yo;
	logic signed [emr_pkg::SUM_W-1:0] xr_sum, xl_sum, yt_sum, yb_sum;

	always_comb begin
		cx     = emr_pkg::SUM_W'(center_x_q);
		cy     = emr_pkg::SUM_W'(center_y_q);
		xo     = emr_pkg::SUM_W'(res.x_off);
		yo     = emr_pkg::SUM_W'(res.y_off);
		xr_sum = cx + xo;
		xl_sum = cx - xo;
		yt_sum = cy + yo;
		yb_sum = cy - yo;
	end

	// Output register: a blank result carries zeros in every point field.
	logic                   m_tvalid_q;
	logic                   tuser_q, tlast_q;
	logic [COORD_WIDTH-1:0] x_right_q, x_left_q, y_top_q, y_bottom_q;

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			tuser_q <= res.valid_res;
			tlast_q <= res.last;
			if (res.valid_res) begin
				x_right_q  <= COORD_WIDTH'(xr_sum);
				x_left_q   <= COORD_WIDTH'(xl_sum);
				y_top_q    <= COORD_WIDTH'(yt_sum);
				y_bottom_q <= COORD_WIDTH'(yb_sum);
			end else begin
				x_right_q  <= '0;
				x_left_q   <= '0;
				y_top_q    <= '0;
				y_bottom_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = tuser_q;
	assign m_tlast  = tlast_q;
	assign m_tdata  = TDATA_W'({y_bottom_q, y_top_q, x_left_q, x_right_q});

endmodule
